FILE: design/tsfp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsfp_pkg
// Shared types and codes for the three-stack fixed-partition block.
// ----------------------------------------------------------------------------
package tsfp_pkg;

    // request operation codes
    typedef enum logic [1:0] {
        MODE_PUSH      = 2'd0,
        MODE_POP       = 2'd1,
        MODE_READ_TOP  = 2'd2,
        MODE_OVERWRITE = 2'd3
    } mode_t;

    // result status codes
    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } status_t;

    localparam int unsigned MODE_W   = 2;
    localparam int unsigned ID_W     = 2;
    localparam int unsigned VALUE_W  = 32;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned DEPTH_W  = 8;
    localparam int unsigned IN_W     = 40;
    localparam int unsigned OUT_W    = 48;

    // result fields held while the memory read completes
    typedef struct packed {
        status_t              status;
        logic [DEPTH_W-1:0]   depth;
        logic                 is_empty;
        logic                 use_rdata;
    } result_t;

endpackage

FILE: design/tsfp_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsfp_ram
// Generic simple dual-port RAM with one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module tsfp_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 384
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read, holds while not enabled
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: design/three_stacks_fixed_partition_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_stacks_fixed_partition_top
// Several LIFO stacks in one shared RAM cut into equal fixed regions.
//
//   channel  direction  width  contents (lowest bit first)
//   s_axis   in         40     mode[1:0], stack_id[3:2], value[35:4]
//   m_axis   out        48     status[1:0], top_value[33:2], depth[41:34],
//                              is_empty[42]
//
// One request per cycle while results are taken; its result appears in the
// cycle after acceptance, set by the registered read of the element RAM.
// Counts sit in flip-flops and are updated at acceptance, so back-to-back
// requests to the same stack see each other without forwarding.
// Reset clears the counts and the result valid flag; the RAM is not cleared.
// A result not taken stalls the input side through s_axis_tready.
// ----------------------------------------------------------------------------
module three_stacks_fixed_partition_top #(
    parameter int unsigned STACK_DEPTH = 128,
    parameter int unsigned NUM_STACKS  = 3
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    // mode, stack_id, value, zero fill
    input  logic [tsfp_pkg::IN_W-1:0]    s_axis_tdata,
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // status, top_value, depth, is_empty, zero fill
    output logic [tsfp_pkg::OUT_W-1:0]   m_axis_tdata
);

    localparam int unsigned MEM_DEPTH = NUM_STACKS * STACK_DEPTH;
    localparam int unsigned ADDR_W    = $clog2(MEM_DEPTH) > 0 ? $clog2(MEM_DEPTH) : 1;
    localparam int unsigned CNT_W     = $clog2(STACK_DEPTH + 1);
    localparam int unsigned SEL_W     = NUM_STACKS > 1 ? $clog2(NUM_STACKS) : 1;
    localparam int unsigned RAM_DEPTH = MEM_DEPTH > 1 ? MEM_DEPTH : 2;

    // input beat fields
    tsfp_pkg::mode_t                   mode;
    logic [tsfp_pkg::ID_W-1:0]         stack_id;
    logic [tsfp_pkg::VALUE_W-1:0]      value;

    logic                              accept;
    logic                              id_ok;
    logic [SEL_W-1:0]                  sel;
    logic [CNT_W-1:0]                  cnt;
    logic [CNT_W-1:0]                  cnt_new;
    logic                              is_full;
    logic                              is_zero;
    logic [ADDR_W-1:0]                 base;
    logic [ADDR_W-1:0]                 addr;
    logic                              wr_en;
    logic                              rd_en;
    logic [tsfp_pkg::VALUE_W-1:0]      rd_data;

    logic [CNT_W-1:0]                  counts_reg [NUM_STACKS];
    logic [CNT_W-1:0]                  counts_next [NUM_STACKS];
    tsfp_pkg::result_t                 res_reg;
    tsfp_pkg::result_t                 res_next;
    logic                              res_valid_reg;
    logic                              res_valid_next;

    assign mode     = tsfp_pkg::mode_t'(s_axis_tdata[1:0]);
    assign stack_id = s_axis_tdata[3:2];
    assign value    = s_axis_tdata[35:4];

    // handshake: the result register frees as it is taken
    assign s_axis_tready = !res_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // selected stack and its count
    assign id_ok   = 32'(stack_id) < NUM_STACKS;
    assign sel     = SEL_W'(stack_id);
    assign cnt     = id_ok ? counts_reg[sel] : '0;
    assign is_full = 32'(cnt) >= STACK_DEPTH;
    assign is_zero = cnt == '0;
    assign base    = ADDR_W'(32'(sel) * STACK_DEPTH);
    assign addr    = (mode == tsfp_pkg::MODE_PUSH) ? base + ADDR_W'(cnt)
                                                   : base + ADDR_W'(cnt) - ADDR_W'(1);

    // operation decode and result fields
    always_comb
    begin
        cnt_new            = cnt;
        wr_en              = 1'b0;
        rd_en              = 1'b0;
        res_next.status    = tsfp_pkg::STATUS_OK;
        res_next.use_rdata = 1'b0;
        if (!id_ok)
        begin
            res_next.status = tsfp_pkg::STATUS_EMPTY;
        end
        else
        begin
            case (mode)
                tsfp_pkg::MODE_PUSH:
                begin
                    if (is_full)
                    begin
                        res_next.status = tsfp_pkg::STATUS_FULL;
                    end
                    else
                    begin
                        wr_en   = accept;
                        cnt_new = cnt + CNT_W'(1);
                    end
                end
                tsfp_pkg::MODE_POP:
                begin
                    if (is_zero)
                    begin
                        res_next.status = tsfp_pkg::STATUS_EMPTY;
                    end
                    else
                    begin
                        cnt_new = cnt - CNT_W'(1);
                    end
                end
                tsfp_pkg::MODE_READ_TOP:
                begin
                    if (is_zero)
                    begin
                        res_next.status = tsfp_pkg::STATUS_EMPTY;
                    end
                    else
                    begin
                        rd_en              = accept;
                        res_next.use_rdata = 1'b1;
                    end
                end
                tsfp_pkg::MODE_OVERWRITE:
                begin
                    if (is_zero)
                    begin
                        res_next.status = tsfp_pkg::STATUS_EMPTY;
                    end
                    else
                    begin
                        wr_en = accept;
                    end
                end
                default:
                begin
                    res_next.status = tsfp_pkg::STATUS_EMPTY;
                end
            endcase
        end
        res_next.depth    = tsfp_pkg::DEPTH_W'(cnt_new);
        res_next.is_empty = cnt_new == '0;
    end

    // count update for the selected stack
    always_comb
    begin
        for (int i = 0; i < NUM_STACKS; i++)
        begin
            counts_next[i] = counts_reg[i];
        end
        if (accept && id_ok)
        begin
            counts_next[sel] = cnt_new;
        end
    end

    assign res_valid_next = accept ? 1'b1 : (m_axis_tready ? 1'b0 : res_valid_reg);

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_STACKS; i++)
            begin
                counts_reg[i] <= '0;
            end
            res_valid_reg <= 1'b0;
        end
        else
        begin
            counts_reg    <= counts_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // result fields, loaded with each accepted beat
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_reg <= res_next;
        end
    end

    // shared element store
    tsfp_ram #(
        .WIDTH (tsfp_pkg::VALUE_W),
        .DEPTH (RAM_DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr ($clog2(RAM_DEPTH)'(addr)),
        .wr_data (value),
        .rd_en   (rd_en),
        .rd_addr ($clog2(RAM_DEPTH)'(addr)),
        .rd_data (rd_data)
    );

    // output beat
    assign m_axis_tvalid = res_valid_reg;
    assign m_axis_tdata  = {
        5'd0,
        res_reg.is_empty,
        res_reg.depth,
        res_reg.use_rdata ? rd_data : '0,
        res_reg.status
    };

endmodule
